// ===== src/rcm_pkg.sv =====
// Shared types and constants for the RSA character exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;

  localparam int VAL_W  = 16;
  localparam int CFG_W  = 16;
  localparam int EXP_W  = 16;
  localparam int RES_W  = 16;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 2;
  localparam int PC_W   = 4;
  localparam int ECNT_W = 5;

  localparam logic [VAL_W-1:0]  CHAR_OFFSET   = 16'd96;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET_C = 8'd96;

  localparam logic [CFG_W-1:0] MODULUS_RST = 16'd2491;
  localparam logic [CFG_W-1:0] ENC_EXP_RST = 16'd3;
  localparam logic [CFG_W-1:0] DEC_EXP_RST = 16'd1595;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_ENC_EXP = 2'd1,
    REG_DEC_EXP = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OPC_ENCRYPT = 1'b0,
    OPC_DECRYPT = 1'b1
  } opc_t;

  // Datapath operations selected by the microcode.
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_INIT   = 4'd1,
    OP_RED    = 4'd2,
    OP_FIX    = 4'd3,
    OP_SQSET  = 4'd4,
    OP_DBL    = 4'd5,
    OP_ADD    = 4'd6,
    OP_SQEND  = 4'd7,
    OP_MULEND = 4'd8,
    OP_ENEXT  = 4'd9,
    OP_OUT    = 4'd10
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    JC_NONE   = 3'd0,
    JC_NSMALL = 3'd1,
    JC_MORE   = 3'd2,
    JC_EBIT0  = 3'd3,
    JC_EMORE  = 3'd4,
    JC_OBUSY  = 3'd5
  } jc_t;

  typedef struct packed {
    op_t             op;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic n_small;
    logic more;
    logic ebit0;
    logic emore;
    logic obusy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/rcm_in_if.sv =====
// Input channel: one character or ciphertext residue per beat.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [rcm_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

// ===== src/rcm_out_if.sv =====
// Result channel: residue and character code per beat.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_out_if;
  logic                       valid;
  logic                       ready;
  logic [rcm_pkg::RES_W-1:0]  residue;
  logic [rcm_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output residue, output char_code, input ready);
  modport sink   (input valid, input residue, input char_code, output ready);
endinterface
`default_nettype wire

// ===== src/rcm_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rcm_pkg::IDX_W-1:0] index;
  logic [rcm_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rcm_ucode_rom.sv =====
// Microcode program for the square-and-multiply sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rcm_ucode_rom (
  input  wire logic [rcm_pkg::PC_W-1:0] pc,
  output rcm_pkg::uword_t               word
);
  import rcm_pkg::*;

  localparam logic [PC_W-1:0] S_INIT  = 4'd0;
  localparam logic [PC_W-1:0] S_RED   = 4'd1;
  localparam logic [PC_W-1:0] S_FIX   = 4'd2;
  localparam logic [PC_W-1:0] S_SQSET = 4'd3;
  localparam logic [PC_W-1:0] S_SQDBL = 4'd4;
  localparam logic [PC_W-1:0] S_SQADD = 4'd5;
  localparam logic [PC_W-1:0] S_SQEND = 4'd6;
  localparam logic [PC_W-1:0] S_MDBL  = 4'd7;
  localparam logic [PC_W-1:0] S_MADD  = 4'd8;
  localparam logic [PC_W-1:0] S_MEND  = 4'd9;
  localparam logic [PC_W-1:0] S_ENEXT = 4'd10;
  localparam logic [PC_W-1:0] S_OUT   = 4'd11;

  always_comb begin
    unique case (pc)
      S_INIT:  word = '{op: OP_INIT,   jc: JC_NSMALL, target: S_OUT};
      S_RED:   word = '{op: OP_RED,    jc: JC_MORE,   target: S_RED};
      S_FIX:   word = '{op: OP_FIX,    jc: JC_NONE,   target: S_INIT};
      S_SQSET: word = '{op: OP_SQSET,  jc: JC_NONE,   target: S_INIT};
      S_SQDBL: word = '{op: OP_DBL,    jc: JC_NONE,   target: S_INIT};
      S_SQADD: word = '{op: OP_ADD,    jc: JC_MORE,   target: S_SQDBL};
      // A clear exponent bit skips the multiply by the base.
      S_SQEND: word = '{op: OP_SQEND,  jc: JC_EBIT0,  target: S_ENEXT};
      S_MDBL:  word = '{op: OP_DBL,    jc: JC_NONE,   target: S_INIT};
      S_MADD:  word = '{op: OP_ADD,    jc: JC_MORE,   target: S_MDBL};
      S_MEND:  word = '{op: OP_MULEND, jc: JC_NONE,   target: S_INIT};
      S_ENEXT: word = '{op: OP_ENEXT,  jc: JC_EMORE,  target: S_SQSET};
      S_OUT:   word = '{op: OP_OUT,    jc: JC_OBUSY,  target: S_OUT};
      default: word = '{op: OP_NOP,    jc: JC_NONE,   target: S_INIT};
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rcm_seq.sv =====
// Microcode sequencer: step counter, jump logic and input handshake.
`timescale 1ns / 1ps
`default_nettype none
module rcm_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rcm_pkg::dp_stat_t stat,
  output rcm_pkg::dp_ctrl_t  ctrl
);
  import rcm_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            taken;

  rcm_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  always_comb begin
    unique case (word.jc)
      JC_NONE:   taken = 1'b0;
      JC_NSMALL: taken = stat.n_small;
      JC_MORE:   taken = stat.more;
      JC_EBIT0:  taken = stat.ebit0;
      JC_EMORE:  taken = stat.emore;
      JC_OBUSY:  taken = stat.obusy;
      default:   taken = 1'b0;
    endcase
  end

  assign in_ready   = (state_r == SEQ_IDLE);
  assign ctrl.start = in_valid && (state_r == SEQ_IDLE);
  assign ctrl.op    = (state_r == SEQ_RUN) ? word.op : OP_NOP;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = '0;
        end
      end
      SEQ_RUN: begin
        if (taken) begin
          pc_nxt = word.target;
        end else if (word.op == OP_OUT) begin
          state_nxt = SEQ_IDLE;
          pc_nxt    = '0;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
        pc_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rcm_dp.sv =====
// Datapath: shared modular adder, operand registers and output register.
`timescale 1ns / 1ps
`default_nettype none
module rcm_dp #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rcm_pkg::dp_ctrl_t           ctrl,
  output rcm_pkg::dp_stat_t                stat,
  input  wire logic                        in_opcode,
  input  wire logic [rcm_pkg::VAL_W-1:0]   in_value,
  input  wire logic [rcm_pkg::CFG_W-1:0]   modulus,
  input  wire logic [rcm_pkg::CFG_W-1:0]   enc_exp,
  input  wire logic [rcm_pkg::CFG_W-1:0]   dec_exp,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [rcm_pkg::RES_W-1:0]        out_residue,
  output logic [rcm_pkg::CHAR_W-1:0]       out_char
);
  import rcm_pkg::*;

  localparam int W       = MOD_WIDTH;
  localparam int CNT_MAX = (W > VAL_W) ? W : VAL_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  logic [W-1:0]       n_r, n_nxt;
  logic [EXP_W-1:0]   e_r, e_nxt;
  logic [VAL_W-1:0]   d_r, d_nxt;
  logic               neg_r, neg_nxt;
  logic [W-1:0]       b_r, b_nxt;
  logic [W-1:0]       r_r, r_nxt;
  logic [W-1:0]       x_r, x_nxt;
  logic [W-1:0]       y_r, y_nxt;
  logic [W-1:0]       p_r, p_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ECNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]   out_res_r, out_res_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;

  logic [W+CFG_W-1:0] n_ext;
  logic [W+RES_W-1:0] r_ext;
  logic [W-1:0]       add_b;
  logic               add_cin;
  logic [W:0]         add_sum;
  logic [W:0]         add_dif;
  logic [W-1:0]       add_res;
  logic [W-1:0]       neg_res;

  assign n_ext = {{W{1'b0}}, modulus};
  assign r_ext = {{RES_W{1'b0}}, r_r};

  // Modular add: p + b + cin reduced once, valid because p and b stay below n.
  assign add_b   = (ctrl.op == OP_ADD) ? (x_r[W-1] ? y_r : '0) : p_r;
  assign add_cin = (ctrl.op == OP_RED) ? d_r[VAL_W-1] : 1'b0;
  assign add_sum = {1'b0, p_r} + {1'b0, add_b} + {{W{1'b0}}, add_cin};
  assign add_dif = add_sum - {1'b0, n_r};
  assign add_res = (add_sum >= {1'b0, n_r}) ? add_dif[W-1:0] : add_sum[W-1:0];
  assign neg_res = n_r - p_r;

  assign stat.n_small = (n_r < W'(2));
  assign stat.more    = (cnt_r != CNT_W'(1));
  assign stat.emore   = (ecnt_r != ECNT_W'(1));
  assign stat.ebit0   = !e_r[EXP_W-1];
  assign stat.obusy   = out_valid_r && !out_ready;

  always_comb begin
    n_nxt         = n_r;
    e_nxt         = e_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    ecnt_nxt      = ecnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_char_nxt  = out_char_r;

    if (ctrl.start) begin
      n_nxt = n_ext[W-1:0];
      if (in_opcode == OPC_DECRYPT) begin
        d_nxt   = in_value;
        neg_nxt = 1'b0;
        e_nxt   = dec_exp;
      end else begin
        e_nxt = enc_exp;
        // Characters below the offset are reduced by magnitude and negated later.
        if (in_value >= CHAR_OFFSET) begin
          d_nxt   = in_value - CHAR_OFFSET;
          neg_nxt = 1'b0;
        end else begin
          d_nxt   = CHAR_OFFSET - in_value;
          neg_nxt = 1'b1;
        end
      end
    end

    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_INIT: begin
        r_nxt   = '0;
        p_nxt   = '0;
        cnt_nxt = CNT_W'(VAL_W);
      end
      OP_RED: begin
        p_nxt   = add_res;
        d_nxt   = {d_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_FIX: begin
        b_nxt    = (neg_r && (p_r != '0)) ? neg_res : p_r;
        r_nxt    = {{(W-1){1'b0}}, 1'b1};
        ecnt_nxt = ECNT_W'(EXP_W);
      end
      OP_SQSET: begin
        x_nxt   = r_r;
        y_nxt   = r_r;
        p_nxt   = '0;
        cnt_nxt = CNT_W'(W);
      end
      OP_DBL: begin
        p_nxt = add_res;
      end
      OP_ADD: begin
        p_nxt   = add_res;
        x_nxt   = {x_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_SQEND: begin
        r_nxt   = p_r;
        x_nxt   = p_r;
        y_nxt   = b_r;
        p_nxt   = '0;
        cnt_nxt = CNT_W'(W);
      end
      OP_MULEND: begin
        r_nxt = p_r;
      end
      OP_ENEXT: begin
        e_nxt    = {e_r[EXP_W-2:0], 1'b0};
        ecnt_nxt = ecnt_r - 1'b1;
      end
      OP_OUT: begin
        if (!stat.obusy) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = r_ext[RES_W-1:0];
          out_char_nxt  = r_ext[CHAR_W-1:0] + CHAR_OFFSET_C;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    e_r        <= e_nxt;
    d_r        <= d_nxt;
    neg_r      <= neg_nxt;
    b_r        <= b_nxt;
    r_r        <= r_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    p_r        <= p_nxt;
    cnt_r      <= cnt_nxt;
    ecnt_r     <= ecnt_nxt;
    out_res_r  <= out_res_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_res_r;
  assign out_char    = out_char_r;

endmodule
`default_nettype wire

// ===== src/rsa_char_modexp.sv =====
// Top level of the RSA character exponentiation block.
// Usage:
//   in_if takes one beat per item: opcode 0 encrypts a character code (the
//   code minus 96, reduced below the modulus), opcode 1 decrypts a residue.
//   out_if returns one beat per item with the residue (value to the selected
//   exponent modulo the modulus) and char_code, the low byte of residue + 96.
//   cfg_if writes the modulus (index 0), the encrypt exponent (index 1) and
//   the decrypt exponent (index 2); it is always ready and is meant to be
//   written only while no item is in flight.
// Operation:
//   One item at a time. After the accepting edge the microcode reduces the
//   value modulo the modulus, then squares for each exponent bit and
//   multiplies by the base for each set bit. The modular multiply is
//   bit-serial: each multiplier bit takes a doubling step and an add step
//   through one shared modular adder.
//   A modulus below two gives residue 0.
// Reset clears the sequencer and the output valid and loads the default keys.
// A stalled receiver holds the result in the output register; the sequencer
// still takes a new item, but waits at its last step until that beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module rsa_char_modexp #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rcm_in_if.sink     in_if,
  rcm_out_if.source  out_if,
  rcm_cfg_if.sink    cfg_if
);
  import rcm_pkg::*;

  logic [CFG_W-1:0] modulus_r, modulus_nxt;
  logic [CFG_W-1:0] enc_exp_r, enc_exp_nxt;
  logic [CFG_W-1:0] dec_exp_r, dec_exp_nxt;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    modulus_nxt = modulus_r;
    enc_exp_nxt = enc_exp_r;
    dec_exp_nxt = dec_exp_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MODULUS: modulus_nxt = cfg_if.data;
        REG_ENC_EXP: enc_exp_nxt = cfg_if.data;
        REG_DEC_EXP: dec_exp_nxt = cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      enc_exp_r <= ENC_EXP_RST;
      dec_exp_r <= DEC_EXP_RST;
    end else begin
      modulus_r <= modulus_nxt;
      enc_exp_r <= enc_exp_nxt;
      dec_exp_r <= dec_exp_nxt;
    end
  end

  rcm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rcm_dp #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_opcode   (in_if.opcode),
    .in_value    (in_if.value),
    .modulus     (modulus_r),
    .enc_exp     (enc_exp_r),
    .dec_exp     (dec_exp_r),
    .out_ready   (out_if.ready),
    .out_valid   (out_if.valid),
    .out_residue (out_if.residue),
    .out_char    (out_if.char_code)
  );

endmodule
`default_nettype wire

// ===== src/rcm_check.sv =====
// Port-level checker for the RSA character exponentiation block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rcm_check (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rcm_pkg::RES_W-1:0]   residue,
  input wire logic [rcm_pkg::CHAR_W-1:0]  char_code
);
  import rcm_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its residue.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(residue))
    else $error("residue changed while stalled");

  // The character code always follows the residue it is sent with.
  a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (char_code == (residue[CHAR_W-1:0] + CHAR_OFFSET_C)))
    else $error("char_code does not match residue");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // A fresh result appears together with the block becoming free again.
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while still busy");

endmodule

bind rsa_char_modexp rcm_check u_rcm_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .residue   (out_if.residue),
  .char_code (out_if.char_code)
);
`default_nettype wire
